// File: hw/rtl/lczc_pkg.sv
// Package for the load cell zero calibration block: shared types, command
// and register codes, and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lczc_pkg;

   // fixed field widths
   localparam int TIME_BITS   = 16;
   localparam int OFFSET_BITS = 20;
   localparam int GAIN_BITS   = 24;
   localparam int TORQUE_BITS = 32;
   localparam int CMD_BITS    = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 24;
   localparam int FRAC_BITS   = 8;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_CAL           = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ_STORED   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ_SUPPLIED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SENSOR_USED = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_WINDOW  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN        = 2'd2;

   // register reset values
   localparam logic [TIME_BITS-1:0] WINDOW_RESET = 16'd1000;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET   = 24'd65536;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   // handshake back from a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/lczc_mul.sv
// Bit-serial signed multiplier: one multiplier (gain) bit per cycle, shift-right
// accumulation. Depends on lczc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lczc_mul #(
   parameter int DIFF_BITS = 21
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        start,
   input  wire logic [DIFF_BITS-1:0]                        multiplicand,
   input  wire logic [lczc_pkg::GAIN_BITS-1:0]              multiplier,
   output lczc_pkg::unit_status_type                        status,
   output logic [DIFF_BITS+lczc_pkg::GAIN_BITS-1:0]         product
);
   import lczc_pkg::*;

   localparam int PROD_BITS = DIFF_BITS + GAIN_BITS;
   localparam int CNT_BITS  = $clog2(GAIN_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(GAIN_BITS - 1);

   logic [DIFF_BITS-1:0] mcand_ff;
   logic [DIFF_BITS:0]   hi_ff, hi_in;
   logic [GAIN_BITS-1:0] lo_ff, lo_in;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 busy_ff, done_ff;

   logic [DIFF_BITS+1:0] hi_ext, addend, sum;
   logic                 last;
   logic [DIFF_BITS+GAIN_BITS:0] full;

   assign last   = (cnt_ff == LAST_STEP);
   assign hi_ext = {hi_ff[DIFF_BITS], hi_ff};
   assign addend = lo_ff[0] ? {{2{mcand_ff[DIFF_BITS-1]}}, mcand_ff} : '0;
   // sign bit of the multiplier has negative weight
   assign sum    = last ? (hi_ext - addend) : (hi_ext + addend);
   assign hi_in  = sum[DIFF_BITS+1:1];
   assign lo_in  = {sum[0], lo_ff[GAIN_BITS-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_BITS'(1);
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= multiplicand;
         hi_ff    <= '0;
         lo_ff    <= multiplier;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign full        = {hi_ff, lo_ff};
   assign product     = full[PROD_BITS-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lczc_div.sv
// Restoring divider, one quotient bit per cycle, for the calibration average.
// Denominator must be nonzero. Depends on lczc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lczc_div #(
   parameter int NUM_BITS = 36,
   parameter int DEN_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [NUM_BITS-1:0]   numerator,
   input  wire logic [DEN_BITS-1:0]   denominator,
   output lczc_pkg::unit_status_type  status,
   output logic [NUM_BITS-1:0]        quotient
);
   import lczc_pkg::*;

   localparam int CNT_BITS = $clog2(NUM_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(NUM_BITS - 1);

   // num_ff shifts the dividend out at the top and the quotient in at the bottom
   logic [NUM_BITS-1:0] num_ff;
   logic [DEN_BITS-1:0] den_ff, rem_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff, done_ff;

   logic [DEN_BITS:0]   trial, trial_sub;
   logic                fits;

   assign trial     = {rem_ff, num_ff[NUM_BITS-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_BITS'(1);
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numerator;
         den_ff <= denominator;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_BITS-2:0], fits};
         rem_ff <= fits ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      end
   end

   assign quotient    = num_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// File: hw/rtl/load_cell_zero_calibration.sv
// Load cell zero calibration top level: control sequencer, calibration state,
// configuration registers and result register. Depends on lczc_pkg, lczc_mul, lczc_div.
//
// One item is worked on at a time. A read item (command 1 or 2) is worked
// out by the bit-serial multiplier, which retires one gain bit per cycle. A
// calibrate item that closes the window with a nonzero count is worked out by
// the restoring divider, which produces one quotient bit per cycle. Every other
// item goes from idle straight to the finish state. A finished result sits in
// the output register, so the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module load_cell_zero_calibration #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // input items
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [lczc_pkg::CMD_BITS-1:0]           req_command,
   input  wire logic                                    req_do_cal,
   input  wire logic [SAMPLE_BITS-1:0]                  req_sample,
   input  wire logic [lczc_pkg::TIME_BITS-1:0]          req_now_ms,
   input  wire logic [lczc_pkg::OFFSET_BITS-1:0]        req_supplied_offset,
   // result items
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [lczc_pkg::TORQUE_BITS-1:0]      rsp_torque,
   output logic                                         rsp_calibrating,
   output logic [lczc_pkg::OFFSET_BITS-1:0]             rsp_offset_now,
   // configuration
   input  wire logic                                    csr_write,
   input  wire logic [lczc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [lczc_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import lczc_pkg::*;

   localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
   localparam int NUM_BITS  = SUM_BITS + FRAC_BITS;
   localparam int DIFF_BITS = ((SAMPLE_BITS + FRAC_BITS > OFFSET_BITS) ?
                               SAMPLE_BITS + FRAC_BITS : OFFSET_BITS) + 1;
   localparam int PROD_BITS = DIFF_BITS + GAIN_BITS;
   localparam int Q_BITS    = PROD_BITS + 1 - FRAC_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [PROD_BITS:0]    ROUND_HALF = (PROD_BITS + 1)'(128);
   localparam logic [TORQUE_BITS-1:0] TORQUE_MAX = {1'b0, {(TORQUE_BITS-1){1'b1}}};
   localparam logic [TORQUE_BITS-1:0] TORQUE_MIN = {1'b1, {(TORQUE_BITS-1){1'b0}}};

   // configuration
   logic                  sensor_used_ff;
   logic [TIME_BITS-1:0]  cal_window_ff;
   logic [GAIN_BITS-1:0]  gain_ff;

   // calibration state
   logic                   prev_request_ff, prev_request_in;
   logic [TIME_BITS-1:0]   window_start_ff, window_start_in;
   logic [SUM_BITS-1:0]    sample_sum_ff, sample_sum_in;
   logic [COUNT_BITS-1:0]  sample_count_ff, sample_count_in;
   logic [OFFSET_BITS-1:0] zero_offset_ff, zero_offset_in;

   // sequencer and staged result
   state_type               state_ff, state_in;
   logic [TORQUE_BITS-1:0]  res_torque_ff, res_torque_in;
   logic                    res_cal_ff, res_cal_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TORQUE_BITS-1:0]  rsp_torque_ff, rsp_torque_in;
   logic                    rsp_cal_ff, rsp_cal_in;
   logic [OFFSET_BITS-1:0]  rsp_offset_ff, rsp_offset_in;

   // arithmetic units
   logic                    mul_start, div_start;
   unit_status_type         mul_status, div_status;
   logic [PROD_BITS-1:0]    mul_product;
   logic [NUM_BITS-1:0]     div_quotient;
   logic [DIFF_BITS-1:0]    diff;
   logic [OFFSET_BITS-1:0]  read_offset;
   logic [NUM_BITS-1:0]     div_num;

   // calibrate step terms
   logic                   rising;
   logic [TIME_BITS-1:0]   start_eff, elapsed;
   logic [SUM_BITS-1:0]    sum_eff;
   logic [COUNT_BITS-1:0]  count_eff;
   logic                   in_window;

   // read rounding and saturation
   logic [PROD_BITS:0]     rounded;
   logic [Q_BITS-1:0]      quot;
   logic                   over_pos, over_neg;
   logic [TORQUE_BITS-1:0] torque_sat;
   logic [OFFSET_BITS-1:0] avg_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_used_ff <= 1'b0;
         cal_window_ff  <= WINDOW_RESET;
         gain_ff        <= GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SENSOR_USED: sensor_used_ff <= csr_data[0];
            CSR_CAL_WINDOW:  cal_window_ff  <= csr_data[TIME_BITS-1:0];
            CSR_GAIN:        gain_ff        <= csr_data[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rising    = req_do_cal && !prev_request_ff;
   assign start_eff = rising ? req_now_ms : window_start_ff;
   assign sum_eff   = rising ? '0 : sample_sum_ff;
   assign count_eff = rising ? '0 : sample_count_ff;
   assign elapsed   = req_now_ms - start_eff;
   assign in_window = req_do_cal && (elapsed <= cal_window_ff);

   // sum * 256 + count / 2, rounds the average half up
   assign div_num = {sum_eff, {FRAC_BITS{1'b0}}} + NUM_BITS'(count_eff >> 1);

   assign read_offset = (req_command == CMD_READ_STORED) ? zero_offset_ff
                                                         : req_supplied_offset;
   assign diff = DIFF_BITS'({req_sample, {FRAC_BITS{1'b0}}}) - DIFF_BITS'(read_offset);

   // floor((p + 128) / 256), then clamp to 32 bits
   assign rounded  = {mul_product[PROD_BITS-1], mul_product} + ROUND_HALF;
   assign quot     = rounded[PROD_BITS:FRAC_BITS];
   assign over_pos = !quot[Q_BITS-1] && (|quot[Q_BITS-2:TORQUE_BITS-1]);
   assign over_neg = quot[Q_BITS-1] && !(&quot[Q_BITS-2:TORQUE_BITS-1]);
   assign torque_sat = over_pos ? TORQUE_MAX :
                       over_neg ? TORQUE_MIN : quot[TORQUE_BITS-1:0];

   assign avg_sat = (|div_quotient[NUM_BITS-1:OFFSET_BITS]) ? OFFSET_MAX
                                                            : div_quotient[OFFSET_BITS-1:0];

   lczc_mul #(
      .DIFF_BITS(DIFF_BITS)
   ) u_lczc_mul (
      .clock       (clock),
      .reset       (reset),
      .start       (mul_start),
      .multiplicand(diff),
      .multiplier  (gain_ff),
      .status      (mul_status),
      .product     (mul_product)
   );

   lczc_div #(
      .NUM_BITS(NUM_BITS),
      .DEN_BITS(COUNT_BITS)
   ) u_lczc_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .numerator  (div_num),
      .denominator(count_eff),
      .status     (div_status),
      .quotient   (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         prev_request_ff <= 1'b0;
         window_start_ff <= '0;
         sample_sum_ff   <= '0;
         sample_count_ff <= '0;
         zero_offset_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         prev_request_ff <= prev_request_in;
         window_start_ff <= window_start_in;
         sample_sum_ff   <= sample_sum_in;
         sample_count_ff <= sample_count_in;
         zero_offset_ff  <= zero_offset_in;
      end
   end

   always_ff @(posedge clock) begin
      res_torque_ff <= res_torque_in;
      res_cal_ff    <= res_cal_in;
      rsp_torque_ff <= rsp_torque_in;
      rsp_cal_ff    <= rsp_cal_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   always_comb begin
      state_in        = state_ff;
      prev_request_in = prev_request_ff;
      window_start_in = window_start_ff;
      sample_sum_in   = sample_sum_ff;
      sample_count_in = sample_count_ff;
      zero_offset_in  = zero_offset_ff;
      res_torque_in   = res_torque_ff;
      res_cal_in      = res_cal_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_torque_in   = rsp_torque_ff;
      rsp_cal_in      = rsp_cal_ff;
      rsp_offset_in   = rsp_offset_ff;
      mul_start       = 1'b0;
      div_start       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_torque_in = '0;
               res_cal_in    = 1'b0;
               state_in      = ST_FINISH;
               case (req_command) inside
                  CMD_CAL: begin
                     if (sensor_used_ff) begin
                        window_start_in = start_eff;
                        sample_sum_in   = sum_eff;
                        sample_count_in = count_eff;
                        if (in_window) begin
                           // count saturates: later samples are dropped
                           if (count_eff != COUNT_MAX) begin
                              sample_sum_in   = sum_eff + SUM_BITS'(req_sample);
                              sample_count_in = count_eff + COUNT_BITS'(1);
                           end
                           res_cal_in      = 1'b1;
                           prev_request_in = 1'b1;
                        end else begin
                           prev_request_in = 1'b0;
                           if (req_do_cal && (count_eff != '0)) begin
                              div_start = 1'b1;
                              state_in  = ST_DIV;
                           end
                        end
                     end
                  end
                  CMD_READ_STORED, CMD_READ_SUPPLIED: begin
                     mul_start = 1'b1;
                     state_in  = ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               res_torque_in = torque_sat;
               state_in      = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               zero_offset_in = avg_sat;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_torque_in = res_torque_ff;
               rsp_cal_in    = res_cal_ff;
               rsp_offset_in = zero_offset_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_torque      = rsp_torque_ff;
   assign rsp_calibrating = rsp_cal_ff;
   assign rsp_offset_now  = rsp_offset_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lczc_checker.sv
// Port-level checks for load_cell_zero_calibration, attached by bind.
// Depends on lczc_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module lczc_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic signed [lczc_pkg::TORQUE_BITS-1:0] rsp_torque,
   input wire logic                                  rsp_calibrating,
   input wire logic [lczc_pkg::OFFSET_BITS-1:0]      rsp_offset_now
);
   import lczc_pkg::*;

   // one item at a time: an accepted item blocks the input next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an item was accepted");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_cal_no_torque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> rsp_torque == '0)
      else $error("torque nonzero on a calibrating result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_torque) &&
         $stable(rsp_calibrating) && $stable(rsp_offset_now))
      else $error("stalled result changed");

endmodule

bind load_cell_zero_calibration lczc_checker u_lczc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_torque     (rsp_torque),
   .rsp_calibrating(rsp_calibrating),
   .rsp_offset_now (rsp_offset_now)
);

`default_nettype wire
